// ===== design/ntgf_pkg.sv =====
`timescale 1ns / 1ps

package ntgf_pkg;

    // Sizing
    localparam int DURATION_BITS   = 24;
    localparam int FADE_SAMPLES    = 441;
    localparam int SINE_TABLE_BITS = 10;

    localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int QUARTER      = 1 << QUARTER_BITS;
    localparam int AMP_BITS     = 15;
    localparam int GAIN_BITS    = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int NOTE_BITS    = 8;
    localparam int NOTE_COUNT   = 1 << NOTE_BITS;

    // Fixed-point constants
    localparam logic [DURATION_BITS-1:0] MIN_SAMPLES = DURATION_BITS'(441);
    localparam logic [GAIN_BITS-1:0]     GAIN_START  = 16'd64225;
    localparam logic [31:0] A4_INC      = 32'd42852281;
    localparam logic [31:0] INC_MIN     = 32'd9739155;
    localparam logic [31:0] INC_MAX     = 32'd2147483648;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] AMPLITUDE   = 32'd32767;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef logic [11:0][16:0]                  ratio_tbl_t;
    typedef logic [QUARTER:0][AMP_BITS-1:0]     quarter_tbl_t;
    typedef logic [NOTE_COUNT-1:0][31:0]        note_tbl_t;

    // round(65536 * 2^(s/12)), entry 0 last
    localparam ratio_tbl_t SEMITONE_RATIO = {
        17'd123715, 17'd116772, 17'd110218, 17'd104032,
        17'd98193,  17'd92682,  17'd87480,  17'd82570,
        17'd77936,  17'd73562,  17'd69433,  17'd65536
    };

    // Quarter-wave entry: Q30 Taylor series through x^13, products truncated
    function automatic logic [AMP_BITS-1:0] quarter_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        x    = (64'(k) * 64'(HALF_PI_Q30)) >> QUARTER_BITS;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (n % 2 == 1)
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        scaled = (sum * 64'(AMPLITUDE) + (64'd1 << 29)) >> 30;
        return scaled[AMP_BITS-1:0];
    endfunction

    function automatic quarter_tbl_t build_quarter();
        quarter_tbl_t tbl;
        for (int k = 0; k <= QUARTER; k++)
            tbl[k] = quarter_entry(k);
        return tbl;
    endfunction

    // Phase increment for one note, clamped to 100 Hz .. 22050 Hz
    function automatic logic [31:0] note_increment(input int note_in);
        int          nt;
        int          d;
        int          oct3;
        int          semi;
        int          shift;
        logic [63:0] prod;
        logic [63:0] inc;
        nt = note_in;
        if (nt < -17)
            nt = -17;
        if (nt > 77)
            nt = 77;
        d     = nt - 9 + 36;
        oct3  = d / 12;
        semi  = d % 12;
        shift = 19 - oct3;
        prod  = 64'(A4_INC) * 64'(SEMITONE_RATIO[semi]);
        inc   = (prod + (64'd1 << (shift - 1))) >> shift;
        if (inc < 64'(INC_MIN))
            inc = 64'(INC_MIN);
        if (inc > 64'(INC_MAX))
            inc = 64'(INC_MAX);
        return inc[31:0];
    endfunction

    // Indexed by the raw two's-complement note bits
    function automatic note_tbl_t build_note_tbl();
        note_tbl_t tbl;
        for (int i = 0; i < NOTE_COUNT; i++)
            tbl[i] = note_increment((i >= NOTE_COUNT / 2) ? i - NOTE_COUNT : i);
        return tbl;
    endfunction

    localparam quarter_tbl_t SINE_QUARTER = build_quarter();
    localparam note_tbl_t    NOTE_INC     = build_note_tbl();

endpackage

// ===== design/note_tone_generator_with_fade_core.sv =====
`timescale 1ns / 1ps

// Note tone generator with end fade.
// Input channel (in_valid / in_stall): operation, note, duration_samples.
//   A start beat loads a note and a duration (raised to 441 if shorter), clears
//   the phase and restarts any tone in progress; it gives no result.
//   A tick beat while a tone is active gives one result beat; a tick while
//   idle is dropped.
// Output channel (out_valid / out_stall): sample (signed 16 bit), last.
//   last marks the final sample of the tone; the tone then goes idle.
// Path: a beat accepted into the input register is processed into the
//   tone state and the output register together, and its result is
//   shown from the output register until it is taken.
// Throughput: one beat per cycle when not stalled; the input register, the
//   state update and the output register all advance together, so the sine
//   lookup and the two fade multiplies are the only work between registers.
// Stall: while out_stall holds a pending result, the pipeline freezes; the
//   input register still takes one beat, then in_stall rises.
// Reset: asynchronous, active low; no tone active, gain back to 0.98,
//   both registers empty. No table needs clearing.
module note_tone_generator_with_fade_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  ntgf_pkg::op_t                         operation,
    input  logic signed [7:0]                     note,
    input  logic [ntgf_pkg::DURATION_BITS-1:0]    duration_samples,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ntgf_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                  last
);
    import ntgf_pkg::*;

    // Input register
    logic                      in_valid_reg;
    op_t                       in_op_reg;
    logic [NOTE_BITS-1:0]      in_note_reg;
    logic [DURATION_BITS-1:0]  in_dur_reg;

    // Tone state
    logic [31:0]               phase_reg,        phase_next;
    logic [31:0]               inc_reg,          inc_next;
    logic [DURATION_BITS-1:0]  samples_left_reg, samples_left_next;
    logic [GAIN_BITS-1:0]      fade_gain_reg,    fade_gain_next;
    logic                      active_reg,       active_next;

    // Output register
    logic                      out_valid_reg,    out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg,   sample_next;
    logic                      last_reg,         last_next;

    logic                      advance;
    logic                      do_start;
    logic                      do_tick;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [QUARTER_BITS-1:0]   off;
    logic [QUARTER_BITS:0]     qidx;
    logic [AMP_BITS-1:0]       mag_raw;
    logic [AMP_BITS+GAIN_BITS-1:0] mag_prod;
    logic [AMP_BITS-1:0]       mag;
    logic [2*GAIN_BITS-1:0]    gain_prod;
    logic                      fading;

    // Handshake: everything moves when the output register can be replaced
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign do_start  = advance && in_valid_reg && (in_op_reg == OP_START);
    assign do_tick   = advance && in_valid_reg && (in_op_reg == OP_TICK) && active_reg;

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_op_reg   <= operation;
            in_note_reg <= note;
            in_dur_reg  <= duration_samples;
        end
    end

    // Sine lookup from the top phase bits, mirrored quarter wave
    always_comb
    begin
        idx     = phase_reg[31 -: SINE_TABLE_BITS];
        quad    = idx[SINE_TABLE_BITS-1 -: 2];
        off     = idx[QUARTER_BITS-1:0];
        qidx    = quad[0] ? ((QUARTER_BITS+1)'(QUARTER) - {1'b0, off}) : {1'b0, off};
        mag_raw = SINE_QUARTER[qidx];
    end

    // Fade gain, magnitude truncated toward zero
    always_comb
    begin
        fading    = (samples_left_reg <= DURATION_BITS'(FADE_SAMPLES));
        mag_prod  = mag_raw * fade_gain_reg;
        mag       = fading ? mag_prod[AMP_BITS+GAIN_BITS-1 -: AMP_BITS] : mag_raw;
        gain_prod = fade_gain_reg * GAIN_START;
    end

    // Next state and result
    always_comb
    begin
        phase_next        = phase_reg;
        inc_next          = inc_reg;
        samples_left_next = samples_left_reg;
        fade_gain_next    = fade_gain_reg;
        active_next       = active_reg;
        out_valid_next    = out_valid_reg;
        sample_next       = sample_reg;
        last_next         = last_reg;

        if (advance)
            out_valid_next = do_tick;

        if (do_start)
        begin
            phase_next        = '0;
            inc_next          = NOTE_INC[in_note_reg];
            samples_left_next = (in_dur_reg < MIN_SAMPLES) ? MIN_SAMPLES : in_dur_reg;
            fade_gain_next    = GAIN_START;
            active_next       = 1'b1;
        end
        else if (do_tick)
        begin
            sample_next = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            last_next   = (samples_left_reg <= DURATION_BITS'(1));
            if (fading)
                fade_gain_next = gain_prod[2*GAIN_BITS-1 -: GAIN_BITS];
            if (samples_left_reg != '0)
                samples_left_next = samples_left_reg - DURATION_BITS'(1);
            if (samples_left_next == '0)
                active_next = 1'b0;
            phase_next = phase_reg + inc_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            inc_reg          <= '0;
            samples_left_reg <= '0;
            fade_gain_reg    <= GAIN_START;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            inc_reg          <= inc_next;
            samples_left_reg <= samples_left_next;
            fade_gain_reg    <= fade_gain_next;
            active_reg       <= active_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

    // An active tone always has samples to give
    a_active_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (samples_left_reg != '0))
        else $error("active tone with no samples left");

    // Gain stays at its start value until the fade window is reached
    a_gain_before_fade: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && (samples_left_reg > DURATION_BITS'(FADE_SAMPLES)))
        |-> (fade_gain_reg == GAIN_START))
        else $error("fade gain moved before the fade window");

    // A start beat never produces a result
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_start |=> !out_valid_reg)
        else $error("result produced by a start beat");

    // The final tick flags last and ends the tone
    a_last_ends_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (do_tick && (samples_left_reg == DURATION_BITS'(1)))
        |=> (out_valid_reg && last_reg && !active_reg))
        else $error("final sample not flagged or tone still active");

endmodule

// ===== bench/note_tone_generator_with_fade_core_test.sv =====
`timescale 1ns / 1ps

module note_tone_generator_with_fade_core_test;

    import ntgf_pkg::*;

    localparam int QBITS          = SINE_TABLE_BITS - 2;
    localparam int QSIZE          = 1 << QBITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 200;

    // round(65536 * 2^(s/12)) per semitone
    localparam logic [16:0] SEMI_RATIO [12] = '{
        17'd65536,  17'd69433,  17'd73562,  17'd77936,
        17'd82570,  17'd87480,  17'd92682,  17'd98193,
        17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } tone_sample_t;

    logic                          clk              = 1'b0;
    logic                          rst_n            = 1'b0;
    logic                          in_valid         = 1'b0;
    logic                          in_stall;
    op_t                           operation        = OP_TICK;
    logic signed [7:0]             note             = '0;
    logic [DURATION_BITS-1:0]      duration_samples = '0;
    logic                          out_valid;
    logic                          out_stall        = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    // Predicted tone state
    logic [31:0]  tone_phase  = '0;
    logic [31:0]  tone_step   = '0;
    int unsigned  tone_left   = 0;
    int unsigned  tone_gain   = GAIN_START;
    bit           tone_active = 1'b0;

    tone_sample_t pending_samples[$];
    int           mismatches    = 0;
    int           beats_sent    = 0;
    bit           no_idle       = 1'b0;
    int           hold_request  = 0;
    int           hold_left     = 0;
    int           stall_wait    = 0;
    int           quiet_cycles  = 0;

    note_tone_generator_with_fade_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .note             (note),
        .duration_samples (duration_samples),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample           (sample),
        .last             (last)
    );

    always #5 clk = ~clk;

    // Quarter-wave amplitude: Q30 Taylor series, truncated products
    function automatic int quarter_amp(input int k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        x    = (64'(k) * 64'(HALF_PI_Q30)) >> QBITS;
        term = x;
        acc  = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = (acc >= term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        return int'((acc * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int sine_at(input logic [31:0] phase);
        logic [SINE_TABLE_BITS-1:0] idx;
        int                         off;
        int                         mag;
        idx = phase[31 -: SINE_TABLE_BITS];
        off = int'(idx[QBITS-1:0]);
        mag = idx[QBITS] ? quarter_amp(QSIZE - off) : quarter_amp(off);
        return idx[QBITS+1] ? -mag : mag;
    endfunction

    // Phase step per sample for a note, clamped to 100 Hz .. 22050 Hz
    function automatic logic [31:0] step_for_note(input int nt);
        int          d;
        int          shift;
        logic [63:0] prod;
        logic [63:0] inc;
        if (nt < -17)
            nt = -17;
        if (nt > 77)
            nt = 77;
        d     = nt + 27;
        shift = 19 - d / 12;
        prod  = 64'(A4_INC) * 64'(SEMI_RATIO[d % 12]);
        inc   = (prod + (64'd1 << (shift - 1))) >> shift;
        if (inc < 64'(INC_MIN))
            inc = 64'(INC_MIN);
        if (inc > 64'(INC_MAX))
            inc = 64'(INC_MAX);
        return inc[31:0];
    endfunction

    // Advance the predicted tone by one accepted beat
    function automatic void tone_predict(input op_t op, input logic signed [7:0] nt,
                                         input logic [DURATION_BITS-1:0] dur);
        int           value;
        logic [63:0]  mag;
        bit           neg;
        tone_sample_t r;
        if (op == OP_START)
        begin
            tone_phase  = '0;
            tone_step   = step_for_note(int'(nt));
            tone_left   = (dur < MIN_SAMPLES) ? int'(MIN_SAMPLES) : int'(dur);
            tone_gain   = GAIN_START;
            tone_active = 1'b1;
        end
        else if (tone_active)
        begin
            value = sine_at(tone_phase);
            if (tone_left <= FADE_SAMPLES)
            begin
                neg       = value < 0;
                mag       = 64'(neg ? -value : value);
                mag       = (mag * 64'(tone_gain)) >> 16;
                value     = neg ? -int'(mag) : int'(mag);
                tone_gain = int'((64'(tone_gain) * 64'(GAIN_START)) >> 16);
            end
            r.sample = SAMPLE_BITS'(value);
            r.last   = (tone_left <= 1);
            pending_samples.push_back(r);
            if (tone_left > 0)
                tone_left--;
            if (tone_left == 0)
                tone_active = 1'b0;
            tone_phase = tone_phase + tone_step;
        end
    endfunction

    // Offer one beat after a random gap, hold it until taken
    task automatic send_beat(input op_t op, input logic signed [7:0] nt,
                             input logic [DURATION_BITS-1:0] dur);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= op;
        note             <= nt;
        duration_samples <= dur;
        do
            @(posedge clk);
        while (in_stall);
        tone_predict(op, nt, dur);
        beats_sent++;
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_beat(OP_TICK, 8'($urandom), DURATION_BITS'($urandom));
    endtask

    // Result side: random stall per beat, long hold on request, checking
    always @(posedge clk)
    begin
        tone_sample_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    $display("%0t: unexpected result sample %0d last %0b",
                             $time, sample, last);
                    mismatches++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (sample !== want.sample)
                    begin
                        $display("%0t: sample expected %0d, actual %0d",
                                 $time, want.sample, sample);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b, actual %0b",
                                 $time, want.last, last);
                        mismatches++;
                    end
                end
                stall_wait = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_wait > 0)
            begin
                out_stall <= 1'b1;
                stall_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("note_tone_generator_with_fade_core_test failed");
                $finish;
            end
        end
    end

    // Tick with no tone: dropped
    task automatic test_idle_tick();
        send_ticks(1);
    endtask

    // A4, note clamps at both ends, widest and shortest durations
    task automatic test_note_extremes();
        send_beat(OP_START, 8'sd9, DURATION_BITS'(1000));
        send_ticks(3);
        send_beat(OP_START, -8'sd128, {DURATION_BITS{1'b1}});
        send_ticks(2);
        send_beat(OP_START, 8'sd127, '0);
        send_ticks(3);
        send_beat(OP_START, -8'sd17, DURATION_BITS'($urandom));
        send_ticks(2);
        send_beat(OP_START, 8'sd77, DURATION_BITS'($urandom));
        send_ticks(2);
    endtask

    // Start in the middle of a tone, twice; the second tone lies wholly in its fade window
    task automatic test_restart();
        send_beat(OP_START, 8'sd40, DURATION_BITS'(500));
        send_ticks(2);
        send_beat(OP_START, 8'sd0, DURATION_BITS'(441));
        send_ticks(2);
    endtask

    // Shortest tone played out to the last sample, then ticks while idle;
    // then a slightly longer tone across the edge of its fade window
    task automatic test_tone_end();
        send_beat(OP_START, 8'($urandom), DURATION_BITS'(0));
        send_ticks(int'(MIN_SAMPLES) + 2);
        send_beat(OP_START, 8'($urandom), DURATION_BITS'(FADE_SAMPLES + 1));
        send_ticks(3);
    endtask

    // Long result hold while ticks keep coming, so the input backs up
    task automatic test_backpressure();
        send_beat(OP_START, 8'($urandom), DURATION_BITS'(3000));
        no_idle      = 1'b1;
        hold_request = LONG_HOLD;
        send_ticks(40);
        no_idle      = 1'b0;
    endtask

    // Mostly started tones with random length of play, some loose beats
    task automatic test_random();
        int first_beat;
        int sel;
        logic [DURATION_BITS-1:0] dur;
        first_beat = beats_sent;
        while (beats_sent - first_beat < 40)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    dur = DURATION_BITS'($urandom_range(0, 520));
                else if (sel < 8)
                    dur = DURATION_BITS'($urandom_range(0, 4095));
                else
                    dur = DURATION_BITS'($urandom);
                send_beat(OP_START, 8'($urandom), dur);
                send_ticks($urandom_range(1, 20));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_beat(op_t'($urandom_range(0, 1)), 8'($urandom),
                              DURATION_BITS'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_tick();
        test_note_extremes();
        test_restart();
        test_tone_end();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("note_tone_generator_with_fade_core_test passed");
        else
            $display("note_tone_generator_with_fade_core_test failed");
        $finish;
    end

endmodule
